// ===== rtl/mbs_pkg.sv =====
package mbs_pkg;

    // Default table depth: longest boundary string in characters
    localparam int unsigned MAX_BOUNDARY_DEF = 70;

    // Length of the CR LF dash dash prefix ahead of the boundary characters
    localparam int unsigned PREFIX_LEN = 4;

    // Input item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_NEW  = 2'd3;

    // Result events
    localparam logic [2:0] EV_DATA      = 3'd0;
    localparam logic [2:0] EV_PART_BEG  = 3'd1;
    localparam logic [2:0] EV_PART_END  = 3'd2;
    localparam logic [2:0] EV_MSG_END   = 3'd3;
    localparam logic [2:0] EV_ERROR     = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_EARLY_END  = 2'd1;
    localparam logic [1:0] ERR_BAD_SUFFIX = 2'd2;

    // Delimiter characters
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;

    // Parser to window commands
    typedef struct packed {
        logic push;      // shift the current byte in
        logic clear;     // drop all held bytes
        logic preamble;  // match "--boundary" rather than "CR LF --boundary"
    } t_win_cmd;

    // Window to parser status
    typedef struct packed {
        logic       hit;     // delimiter completed by the pushed byte
        logic       spill;   // oldest held byte left the window
        logic [7:0] oldest;  // byte that left the window
    } t_win_stat;

endpackage

// ===== rtl/mbs_table.sv =====
module mbs_table #(
    parameter int unsigned MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEF,
    localparam int unsigned PLEN = MAX_BOUNDARY + mbs_pkg::PREFIX_LEN
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [6:0]                i_index,
    input  logic [7:0]                i_char,
    output logic [PLEN-1:0][7:0]      o_pattern
);

    logic [7:0] r_table [MAX_BOUNDARY];
    logic [7:0] index_ext;

    assign index_ext = {1'b0, i_index};

    assign o_pattern[0] = mbs_pkg::CH_CR;
    assign o_pattern[1] = mbs_pkg::CH_LF;
    assign o_pattern[2] = mbs_pkg::CH_DASH;
    assign o_pattern[3] = mbs_pkg::CH_DASH;

    // Indexes beyond the table match no entry, so such writes drop out
    for (genvar j = 0; j < MAX_BOUNDARY; j++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_we && index_ext == 8'(j)) begin
                r_table[j] <= i_char;
            end
        end
        assign o_pattern[j + mbs_pkg::PREFIX_LEN] = r_table[j];
    end

endmodule

// ===== rtl/mbs_window.sv =====
module mbs_window #(
    parameter int unsigned MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEF,
    localparam int unsigned PLEN = MAX_BOUNDARY + mbs_pkg::PREFIX_LEN,
    localparam int unsigned WLEN = MAX_BOUNDARY + 3,
    localparam int unsigned CW   = $clog2(MAX_BOUNDARY + 4),
    localparam int unsigned LW   = $clog2(MAX_BOUNDARY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mbs_pkg::t_win_cmd     i_cmd,
    input  logic [7:0]            i_byte,
    input  logic [LW-1:0]         i_eff_len,
    input  logic [PLEN-1:0][7:0]  i_pattern,
    output mbs_pkg::t_win_stat    o_stat
);

    logic [7:0]    r_win [WLEN];
    logic [CW-1:0] r_count;

    logic [CW-1:0]   cap;
    logic [CW-1:0]   cap_m1;
    logic [CW-1:0]   last_pos;
    logic            full;
    logic [WLEN-1:0] eq_win;
    logic [PLEN-1:0] eq_tail;
    logic            hit;
    logic            spill;

    // Window capacity is one short of the pattern being matched
    assign cap      = CW'(i_eff_len) + (i_cmd.preamble ? CW'(1) : CW'(3));
    assign cap_m1   = cap - CW'(1);
    assign last_pos = CW'(i_eff_len) + CW'(3);
    assign full     = (r_count == cap);

    // Compare every held byte with its pattern byte in parallel
    for (genvar i = 0; i < WLEN; i++) begin : g_cmp
        if (i + 2 < PLEN) begin : g_both
            assign eq_win[i] = (CW'(i) >= cap) ||
                               (r_win[i] == (i_cmd.preamble ? i_pattern[i + 2] : i_pattern[i]));
        end else begin : g_part
            assign eq_win[i] = (CW'(i) >= cap) || (!i_cmd.preamble && r_win[i] == i_pattern[i]);
        end
    end

    // Incoming byte against the final boundary character
    for (genvar j = 0; j < PLEN; j++) begin : g_tail
        assign eq_tail[j] = (CW'(j) == last_pos) && (i_byte == i_pattern[j]);
    end

    assign hit   = i_cmd.push && full && (&eq_win) && (|eq_tail);
    assign spill = i_cmd.push && full && !hit;

    assign o_stat.hit    = hit;
    assign o_stat.spill  = spill;
    assign o_stat.oldest = r_win[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            if (!full) begin
                r_count <= r_count + CW'(1);
            end else if (hit) begin
                r_count <= '0;
            end
        end
    end

    // Fill at the count while filling; once full, shift towards entry 0
    for (genvar i = 0; i < WLEN; i++) begin : g_win
        if (i + 1 < WLEN) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_cmd.push && !full && r_count == CW'(i)) begin
                    r_win[i] <= i_byte;
                end else if (spill && CW'(i) == cap_m1) begin
                    r_win[i] <= i_byte;
                end else if (spill && CW'(i) < cap_m1) begin
                    r_win[i] <= r_win[i + 1];
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_cmd.push && !full && r_count == CW'(i)) begin
                    r_win[i] <= i_byte;
                end else if (spill && CW'(i) == cap_m1) begin
                    r_win[i] <= i_byte;
                end
            end
        end
    end

endmodule

// ===== rtl/mbs_parser.sv =====
module mbs_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_item_valid,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_byte,
    input  mbs_pkg::t_win_stat i_win_stat,
    output mbs_pkg::t_win_cmd  o_win_cmd,
    output logic               o_take,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_event_res,
    output logic [7:0]         o_data_byte,
    output logic [1:0]         o_error_code
);

    typedef enum logic [2:0] {
        PH_PREAMBLE,
        PH_SUFFIX1,
        PH_SUFFIX2,
        PH_PART,
        PH_DONE,
        PH_FAILED
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sfb, n_sfb;
    logic       r_out_valid;
    logic [2:0] r_event, n_event;
    logic [7:0] r_data, n_data;
    logic [1:0] r_err, n_err;
    logic       take;
    logic       res;
    mbs_pkg::t_win_cmd cmd;

    assign take = i_item_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_phase      = r_phase;
        n_sfb        = r_sfb;
        n_event      = mbs_pkg::EV_DATA;
        n_data       = 8'h00;
        n_err        = mbs_pkg::ERR_NONE;
        res          = 1'b0;
        cmd.push     = 1'b0;
        cmd.clear    = 1'b0;
        cmd.preamble = (r_phase == PH_PREAMBLE);
        if (i_cfg_we) begin
            n_phase   = PH_PREAMBLE;
            cmd.clear = 1'b1;
        end else if (take) begin
            unique case (i_kind)
                mbs_pkg::KIND_LOAD: begin
                end
                mbs_pkg::KIND_NEW: begin
                    n_phase   = PH_PREAMBLE;
                    cmd.clear = 1'b1;
                end
                mbs_pkg::KIND_END: begin
                    if (r_phase != PH_DONE && r_phase != PH_FAILED) begin
                        n_phase   = PH_FAILED;
                        cmd.clear = 1'b1;
                        res       = 1'b1;
                        n_event   = mbs_pkg::EV_ERROR;
                        n_err     = mbs_pkg::ERR_EARLY_END;
                    end
                end
                mbs_pkg::KIND_BYTE: begin
                    unique case (r_phase)
                        PH_PREAMBLE: begin
                            cmd.push = 1'b1;
                            if (i_win_stat.hit) begin
                                n_phase = PH_SUFFIX1;
                            end
                        end
                        PH_SUFFIX1: begin
                            n_sfb   = i_byte;
                            n_phase = PH_SUFFIX2;
                        end
                        PH_SUFFIX2: begin
                            res = 1'b1;
                            if (r_sfb == mbs_pkg::CH_CR && i_byte == mbs_pkg::CH_LF) begin
                                n_phase   = PH_PART;
                                cmd.clear = 1'b1;
                                n_event   = mbs_pkg::EV_PART_BEG;
                            end else if (r_sfb == mbs_pkg::CH_DASH &&
                                         i_byte == mbs_pkg::CH_DASH) begin
                                n_phase = PH_DONE;
                                n_event = mbs_pkg::EV_MSG_END;
                            end else begin
                                n_phase = PH_FAILED;
                                n_event = mbs_pkg::EV_ERROR;
                                n_err   = mbs_pkg::ERR_BAD_SUFFIX;
                            end
                        end
                        PH_PART: begin
                            cmd.push = 1'b1;
                            if (i_win_stat.hit) begin
                                n_phase = PH_SUFFIX1;
                                res     = 1'b1;
                                n_event = mbs_pkg::EV_PART_END;
                            end else if (i_win_stat.spill) begin
                                res     = 1'b1;
                                n_event = mbs_pkg::EV_DATA;
                                n_data  = i_win_stat.oldest;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREAMBLE;
            r_sfb       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sfb   <= n_sfb;
            if (take && res) begin
                r_out_valid <= 1'b1;
                r_event     <= n_event;
                r_data      <= n_data;
                r_err       <= n_err;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_win_cmd    = cmd;
    assign o_take       = take;
    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_event;
    assign o_data_byte  = r_data;
    assign o_error_code = r_err;

endmodule

// ===== rtl/multipart_boundary_splitter_unit.sv =====
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// input     | i_in_valid / o_in_ready   | i_kind, i_char_index, i_byte_value
// result    | o_out_valid / i_out_ready | o_event_res, o_data_byte, o_error_code
// config    | i_cfg_we (no wait)        | i_cfg_wdata (boundary length)
//
// One input transaction is taken every cycle unless the result side stalls. A
// transaction waits in the input register until the parser takes it; its result
// (if any) is loaded into the result register at that take, so o_out_valid rises
// in the cycle after it. The rate is set by the parallel compare of the held window
// against the boundary table. Synchronous active-low reset clears the phase, the
// held count and both valid flags; table and window contents are not cleared.
// A stalled result holds the result register; the input register then holds too,
// and o_in_ready drops once the input register is occupied.
module multipart_boundary_splitter_unit #(
    parameter int unsigned MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [6:0] i_char_index,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_error_code
);

    localparam int unsigned PLEN = MAX_BOUNDARY + mbs_pkg::PREFIX_LEN;
    localparam int unsigned LW   = $clog2(MAX_BOUNDARY + 1);

    // Input register
    logic       r_in_valid;
    logic [1:0] r_kind;
    logic [6:0] r_char_index;
    logic [7:0] r_byte;

    // Boundary length register, reset to one character
    logic [6:0] r_boundary_length;

    logic                 take;
    logic [7:0]           len_ext;
    logic [LW-1:0]        eff_len;
    logic [PLEN-1:0][7:0] pattern;
    mbs_pkg::t_win_cmd    win_cmd;
    mbs_pkg::t_win_stat   win_stat;

    // Accept a new transaction whenever the input register is empty or the held one moves on this cycle
    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind       <= i_kind;
            r_char_index <= i_char_index;
            r_byte       <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boundary_length <= 7'd1;
        end else if (i_cfg_we) begin
            r_boundary_length <= i_cfg_wdata;
        end
    end

    // Clamp the length: zero acts as one, anything above the table depth as the depth
    assign len_ext = {1'b0, r_boundary_length};
    assign eff_len = (len_ext == 8'd0)                ? LW'(1) :
                     (len_ext > 8'(MAX_BOUNDARY))     ? LW'(MAX_BOUNDARY) :
                                                        LW'(len_ext);

    mbs_table #(
        .MAX_BOUNDARY (MAX_BOUNDARY)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (take && r_kind == mbs_pkg::KIND_LOAD),
        .i_index   (r_char_index),
        .i_char    (r_byte),
        .o_pattern (pattern)
    );

    mbs_window #(
        .MAX_BOUNDARY (MAX_BOUNDARY)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (win_cmd),
        .i_byte    (r_byte),
        .i_eff_len (eff_len),
        .i_pattern (pattern),
        .o_stat    (win_stat)
    );

    // Phase control and result register
    mbs_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_item_valid (r_in_valid),
        .i_kind       (r_kind),
        .i_byte       (r_byte),
        .i_win_stat   (win_stat),
        .o_win_cmd    (win_cmd),
        .o_take       (take),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_event_res  (o_event_res),
        .o_data_byte  (o_data_byte),
        .o_error_code (o_error_code)
    );

endmodule

// ===== rtl/mbs_checker.sv =====
module mbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [6:0] i_cfg_wdata,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_kind,
    input logic [6:0] i_char_index,
    input logic [7:0] i_byte_value,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_event_res,
    input logic [7:0] o_data_byte,
    input logic [1:0] o_error_code
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_event_res) && $stable(o_data_byte) &&
            $stable(o_error_code))
        else $error("result transaction changed while stalled");

    // Error code is set exactly on error events
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_event_res == mbs_pkg::EV_ERROR) ==
                         (o_error_code != mbs_pkg::ERR_NONE)))
        else $error("error code does not agree with event");

    // Data byte is zero on every event but part data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res != mbs_pkg::EV_DATA |-> o_data_byte == 8'h00)
        else $error("data byte set on a non-data event");

    // With the result side free, input is never held off
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while result side is free");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind multipart_boundary_splitter_unit mbs_checker u_mbs_checker (.*);

// ===== verif/mbs_tb_pkg.sv =====
package mbs_tb_pkg;

    import mbs_pkg::*;

    // Offset into "CR LF --" at which the preamble match starts ("--boundary")
    localparam int unsigned PREAMBLE_OFS = 2;

    typedef enum logic [2:0] {
        PH_PREAMBLE,
        PH_SUFFIX1,
        PH_SUFFIX2,
        PH_PART,
        PH_DONE,
        PH_FAILED
    } parse_phase_e;

    typedef enum int {
        WIN_HELD,
        WIN_HIT,
        WIN_SPILL
    } window_step_e;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] data;
        logic [1:0] err;
    } part_event_t;

    class mbs_scoreboard;
        bit [7:0]     bnd_tbl[MAX_BOUNDARY_DEF];
        bit [7:0]     held[MAX_BOUNDARY_DEF + 3];
        int unsigned  held_cnt;
        parse_phase_e phase;
        bit [7:0]     sfx_first;
        bit [6:0]     len_reg;
        part_event_t  expected_events[$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
            reset_state();
        endfunction

        function void reset_state();
            len_reg   = 7'd1;
            held_cnt  = 0;
            phase     = PH_PREAMBLE;
            sfx_first = 8'h00;
            expected_events.delete();
        endfunction

        // A length write restarts the parse
        function void set_length(bit [6:0] v);
            len_reg  = v;
            held_cnt = 0;
            phase    = PH_PREAMBLE;
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        function int unsigned eff_len();
            if (len_reg == 0) return 1;
            if (len_reg > MAX_BOUNDARY_DEF) return MAX_BOUNDARY_DEF;
            return len_reg;
        endfunction

        function bit [7:0] delim_byte(int unsigned start, int unsigned i);
            int unsigned j;
            j = start + i;
            if (j == 0) return CH_CR;
            if (j == 1) return CH_LF;
            if (j < PREFIX_LEN) return CH_DASH;
            return bnd_tbl[j - PREFIX_LEN];
        endfunction

        // Shift one byte through the holding window
        function window_step_e shift_in(int unsigned start, bit [7:0] b,
                                        output bit [7:0] oldest);
            int unsigned cap;
            int unsigned i;
            bit          hit;
            cap    = PREFIX_LEN - start + eff_len() - 1;
            oldest = 8'h00;
            if (held_cnt < cap) begin
                held[held_cnt] = b;
                held_cnt++;
                return WIN_HELD;
            end
            hit = (b == delim_byte(start, cap));
            for (i = 0; i < cap; i++) begin
                if (held[i] != delim_byte(start, i)) hit = 1'b0;
            end
            if (hit) begin
                held_cnt = 0;
                return WIN_HIT;
            end
            oldest = held[0];
            for (i = 0; i + 1 < cap; i++) held[i] = held[i + 1];
            held[cap - 1] = b;
            return WIN_SPILL;
        endfunction

        // Note one accepted input transaction and queue the event it causes
        function void take_item(logic [1:0] kind, logic [6:0] idx, logic [7:0] b);
            part_event_t  e;
            bit [7:0]     oldest;
            window_step_e r;
            e = '{ev: EV_DATA, data: 8'h00, err: ERR_NONE};
            case (kind)
                KIND_LOAD: begin
                    if (idx < MAX_BOUNDARY_DEF) bnd_tbl[idx] = b;
                    return;
                end
                KIND_NEW: begin
                    phase    = PH_PREAMBLE;
                    held_cnt = 0;
                    return;
                end
                KIND_END: begin
                    if (phase == PH_DONE || phase == PH_FAILED) return;
                    phase    = PH_FAILED;
                    held_cnt = 0;
                    e.ev     = EV_ERROR;
                    e.err    = ERR_EARLY_END;
                end
                default: begin
                    case (phase)
                        PH_PREAMBLE: begin
                            if (shift_in(PREAMBLE_OFS, b, oldest) == WIN_HIT) phase = PH_SUFFIX1;
                            return;
                        end
                        PH_SUFFIX1: begin
                            sfx_first = b;
                            phase     = PH_SUFFIX2;
                            return;
                        end
                        PH_SUFFIX2: begin
                            if (sfx_first == CH_CR && b == CH_LF) begin
                                phase    = PH_PART;
                                held_cnt = 0;
                                e.ev     = EV_PART_BEG;
                            end else if (sfx_first == CH_DASH && b == CH_DASH) begin
                                phase = PH_DONE;
                                e.ev  = EV_MSG_END;
                            end else begin
                                phase = PH_FAILED;
                                e.ev  = EV_ERROR;
                                e.err = ERR_BAD_SUFFIX;
                            end
                        end
                        PH_PART: begin
                            r = shift_in(0, b, oldest);
                            if (r == WIN_HELD) return;
                            if (r == WIN_HIT) begin
                                phase = PH_SUFFIX1;
                                e.ev  = EV_PART_END;
                            end else begin
                                e.data = oldest;
                            end
                        end
                        default: return;
                    endcase
                end
            endcase
            expected_events.push_back(e);
        endfunction

        function void report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endfunction

        function void check_result(logic [2:0] ev, logic [7:0] data, logic [1:0] err);
            part_event_t e;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event %0d data %02h err %0d",
                                          ev, data, err));
                return;
            end
            e = expected_events.pop_front();
            if (ev !== e.ev)
                report_mismatch($sformatf("event %0d, expected %0d", ev, e.ev));
            if (data !== e.data)
                report_mismatch($sformatf("data byte %02h, expected %02h", data, e.data));
            if (err !== e.err)
                report_mismatch($sformatf("error code %0d, expected %0d", err, e.err));
        endfunction
    endclass

endpackage

// ===== verif/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mbs_pkg::*;
    import mbs_tb_pkg::*;

    // Byte, end and new transactions to send before stopping the random part
    localparam int unsigned TOTAL_BYTES    = 1450;
    // Bytes per configuration phase, small and long boundaries
    localparam int unsigned PHASE_BYTES    = 160;
    // Cycles without any transaction before the run is abandoned
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    // Acceptance to result passes the input and result registers; allow a margin for silent transactions
    localparam int unsigned SETTLE_CYCLES  = 6;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [6:0] i_cfg_wdata  = 7'd0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_kind       = KIND_LOAD;
    logic [6:0] i_char_index = 7'd0;
    logic [7:0] i_byte_value = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready  = 1'b0;
    logic [2:0] o_event_res;
    logic [7:0] o_data_byte;
    logic [1:0] o_error_code;

    mbs_scoreboard part_events = new();

    // Copy of the boundary table as loaded, used to build well-formed streams
    bit [7:0]    bnd_mirror[MAX_BOUNDARY_DEF];
    // When set, neither side idles
    bit          quiet        = 1'b0;
    int unsigned byte_count   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned stall_left   = 0;

    multipart_boundary_splitter_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_char_index (i_char_index),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_data_byte  (o_data_byte),
        .o_error_code (o_error_code)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Characters that make partial delimiter matches likely
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return CH_CR;
            1:       return CH_LF;
            2, 3:    return CH_DASH;
            4, 5:    return "a";
            6:       return "b";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Watchdog: abandon the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: check every accepted result, then decide whether to stall.
    // Values sampled here are those from before the edge, so no race with the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            part_events.check_result(o_event_res, o_data_byte, o_error_code);
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 20) stall_left = 1 + gap_len();
        end
    end

    // Offer one input transaction and hold it until accepted. Valid is lowered here
    // only ahead of a gap, so back-to-back transactions keep it high.
    task automatic push_item(logic [1:0] kind, logic [6:0] idx, logic [7:0] val);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_char_index <= idx;
        i_byte_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        part_events.take_item(kind, idx, val);
        if (kind == KIND_LOAD && idx < MAX_BOUNDARY_DEF) bnd_mirror[idx] = val;
        if (kind != KIND_LOAD) byte_count++;
    endtask

    // Stream byte; the index field is don't-care here, so randomise it
    task automatic send_byte(logic [7:0] b);
        push_item(KIND_BYTE, 7'($urandom_range(0, 127)), b);
    endtask

    // "--boundary", optionally preceded by CR LF
    task automatic send_boundary(bit with_crlf);
        int unsigned i;
        if (with_crlf) begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
        send_byte(CH_DASH);
        send_byte(CH_DASH);
        for (i = 0; i < part_events.eff_len(); i++) send_byte(bnd_mirror[i]);
    endtask

    // Write every table entry in use for the current length
    task automatic load_boundary();
        int unsigned i;
        for (i = 0; i < part_events.eff_len(); i++) push_item(KIND_LOAD, 7'(i), pick_char());
    endtask

    // Hold the sender until every expected result has arrived, then let any
    // silent transaction still in the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (part_events.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Length writes only happen with the block idle
    task automatic write_length(bit [6:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        part_events.set_length(v);
    endtask

    // One message: preamble, delimiter, a few parts, then a closing or broken tail
    task automatic send_message();
        int unsigned n;
        int unsigned k;
        int unsigned i;
        int unsigned parts;
        if ($urandom_range(0, 9) < 8) push_item(KIND_NEW, 7'($urandom_range(0, 127)),
                                                8'($urandom_range(0, 255)));
        n = $urandom_range(0, 6);
        repeat (n) send_byte(pick_char());
        send_boundary($urandom_range(0, 3) == 0);
        parts = $urandom_range(0, 3);
        repeat (parts) begin
            send_byte(CH_CR);
            send_byte(CH_LF);
            n = $urandom_range(0, 12);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0) begin
                    // partial delimiter inside the part content
                    k = $urandom_range(0, part_events.eff_len() - 1);
                    send_byte(CH_CR);
                    send_byte(CH_LF);
                    send_byte(CH_DASH);
                    send_byte(CH_DASH);
                    for (i = 0; i < k; i++) send_byte(bnd_mirror[i]);
                end else begin
                    send_byte(pick_char());
                end
            end
            send_boundary(1'b1);
        end
        case ($urandom_range(0, 19))
            0: begin
                // bad suffix after the delimiter
                send_byte(CH_CR);
                send_byte(CH_DASH);
            end
            1: push_item(KIND_END, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
            2: ;  // abandon between delimiter and suffix
            3: begin
                // end of input inside a part
                send_byte(CH_CR);
                send_byte(CH_LF);
                repeat ($urandom_range(0, 8)) send_byte(pick_char());
                push_item(KIND_END, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
            end
            default: begin
                send_byte(CH_DASH);
                send_byte(CH_DASH);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0)
                    push_item(KIND_END, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial begin
        bit [6:0]    lengths[8];
        int unsigned p;
        int unsigned target;
        int unsigned i;

        // Lengths cover zero, the reset value, the table depth and beyond it
        lengths = '{7'd0, 7'd1, 7'd127, 7'd2, 7'd70, 7'd3, 7'd71, 7'd1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        part_events.reset_state();

        // Fill the whole table so no compare ever sees an unwritten entry
        for (i = 0; i < MAX_BOUNDARY_DEF; i++) push_item(KIND_LOAD, 7'(i), pick_char());

        // Directed part, boundary length still at its reset value
        push_item(KIND_LOAD, 7'd127, 8'hFF);       // index past the table: dropped
        push_item(KIND_LOAD, 7'd0, "Q");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_boundary(1'b0);                        // delimiter found mid-preamble
        send_byte(CH_CR);
        send_byte(CH_LF);                           // part begins
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_boundary(1'b1);                        // held bytes spill, then part ends
        send_byte("X");
        send_byte("Y");                             // bad suffix
        push_item(KIND_END, 7'd0, 8'h00);           // already failed: silent
        push_item(KIND_NEW, 7'd127, 8'hFF);
        send_boundary(1'b0);
        send_byte(CH_DASH);
        send_byte(CH_DASH);                         // message end
        send_byte(8'h7F);                           // epilogue: ignored
        push_item(KIND_NEW, 7'd0, 8'h00);
        send_byte(8'h55);
        push_item(KIND_END, 7'd127, 8'hFF);         // input ends in the preamble

        // Random part: one boundary length per phase, some phases without idling
        p = 0;
        while (byte_count < TOTAL_BYTES) begin
            write_length(p < 8 ? lengths[p] : 7'($urandom_range(1, 12)));
            quiet  = (p % 4 == 3);
            load_boundary();
            target = byte_count + PHASE_BYTES;
            while (byte_count < target && byte_count < TOTAL_BYTES) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 4))
                        push_item(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                                  8'($urandom_range(0, 255)));
                end else begin
                    send_message();
                end
                // hold the sender until the result side has caught up
                if ($urandom_range(0, 7) == 0) drain_results();
            end
            p++;
        end

        drain_results();
        if (part_events.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mbs_pkg.sv
rtl/mbs_table.sv
rtl/mbs_window.sv
rtl/mbs_parser.sv
rtl/multipart_boundary_splitter_unit.sv
rtl/mbs_checker.sv
verif/mbs_tb_pkg.sv
verif/tb_top.sv
